// ===== design/adq_pkg.sv =====
// ----------------------------------------------------------------------------
// adq_pkg
// Shared codes and types for the array double-ended queue.
// ----------------------------------------------------------------------------
package adq_pkg;

  // command codes
  localparam logic [1:0] CMD_INS_FRONT = 2'd0;
  localparam logic [1:0] CMD_INS_REAR  = 2'd1;
  localparam logic [1:0] CMD_DEL_FRONT = 2'd2;
  localparam logic [1:0] CMD_DEL_REAR  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam int unsigned WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  // per-transaction write controls broadcast along the row of cells
  typedef struct packed {
    logic ins_front;  // shift head..tail up, word goes to head
    logic ins_rear;   // word goes to tail + 1
    logic ins_first;  // queue was empty, word goes to slot 0
  } cell_ctl_t;

endpackage

// ===== design/adq_if.sv =====
// ----------------------------------------------------------------------------
// adq_cmd_if / adq_res_if
// Valid/ready channels carrying commands into and results out of the queue.
// ----------------------------------------------------------------------------
interface adq_cmd_if import adq_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  word_t       data_in;

  modport source (output valid, output command, output data_in, input ready);
  modport sink   (input valid, input command, input data_in, output ready);
endinterface

interface adq_res_if import adq_pkg::*; ();
  logic        valid;
  logic        ready;
  word_t       data_out;
  logic [1:0]  status;

  modport source (output valid, output data_out, output status, input ready);
  modport sink   (input valid, input data_out, input status, output ready);
endinterface

// ===== design/adq_cell.sv =====
// ----------------------------------------------------------------------------
// adq_cell
// One slot of the queue store. Loads the new word, takes its lower
// neighbour's word on a front insert, and drives its word onto the read
// bus when its position is selected.
// ----------------------------------------------------------------------------
module adq_cell import adq_pkg::*; #(
  parameter int unsigned AW  = 7,
  parameter int unsigned IDX = 0
) (
  input  logic          clk,
  input  cell_ctl_t     ctl,
  input  logic [AW-1:0] head,
  input  logic [AW-1:0] tail_inc,
  input  logic [AW-1:0] rd_pos,
  input  word_t         word,
  input  word_t         prev,
  output word_t         slot,
  output word_t         rd_word
);

  localparam logic [AW-1:0] POS = AW'(IDX);

  logic at_head;
  logic in_shift;
  logic at_rear;

  // role of this cell in the current transaction
  assign at_head  = (POS == head);
  assign in_shift = (POS > head) && (POS <= tail_inc);
  assign at_rear  = (POS == tail_inc);

  // slot register
  always_ff @(posedge clk) begin
    if (ctl.ins_first && (POS == '0)) begin
      slot <= word;
    end else if (ctl.ins_front && at_head) begin
      slot <= word;
    end else if (ctl.ins_front && in_shift) begin
      slot <= prev;
    end else if (ctl.ins_rear && at_rear) begin
      slot <= word;
    end
  end

  // gated read onto the shared bus
  assign rd_word = (POS == rd_pos) ? slot : '0;

endmodule

// ===== design/array_double_ended_queue_top.sv =====
// ----------------------------------------------------------------------------
// array_double_ended_queue_top
// Double-ended queue of signed 32-bit words in a row of DEPTH slot cells.
// ----------------------------------------------------------------------------
// Each command (insert front, insert rear, delete front, delete rear) yields
// one result: the deleted word, or 0 for inserts, with a status (ok, overflow
// refused, underflow with data -1). The result is registered and a new
// command is taken in the cycle the result is taken, so with a ready sink
// the block sustains one command per cycle. A front insert moves every
// occupied word up one cell at once through the neighbour links of the cell
// row. The queue reports full once the rear sits on the last slot, even if
// the front has moved up. No clearing pass is made after reset.
// ----------------------------------------------------------------------------
module array_double_ended_queue_top import adq_pkg::*; #(
  parameter int unsigned DEPTH = 128
) (
  input  logic      clk,
  input  logic      rst,
  adq_cmd_if.sink   cmd_ch,
  adq_res_if.source res_ch
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic          empty;
  logic [AW-1:0] head_next;
  logic [AW-1:0] tail_next;
  logic          empty_next;

  logic          res_valid;
  word_t         res_data;
  logic [1:0]    res_status;
  word_t         data_next;
  logic [1:0]    status_next;

  logic          accept;
  logic          full;
  logic          is_ins;
  logic [AW-1:0] tail_inc;
  logic [AW-1:0] rd_pos;
  cell_ctl_t     ctl;
  word_t         rd_data;

  word_t         slot_q [DEPTH];
  word_t         rd_word [DEPTH];

  // handshake
  assign cmd_ch.ready = !res_valid || res_ch.ready;
  assign accept       = cmd_ch.valid && cmd_ch.ready;

  assign full     = !empty && (tail == LAST);
  assign is_ins   = (cmd_ch.command == CMD_INS_FRONT) || (cmd_ch.command == CMD_INS_REAR);
  assign tail_inc = tail + AW'(1);
  assign rd_pos   = (cmd_ch.command == CMD_DEL_FRONT) ? head : tail;

  // write controls for the cell row
  always_comb begin
    ctl           = '0;
    ctl.ins_first = accept && is_ins && empty;
    ctl.ins_front = accept && !empty && !full && (cmd_ch.command == CMD_INS_FRONT);
    ctl.ins_rear  = accept && !empty && !full && (cmd_ch.command == CMD_INS_REAR);
  end

  // row of slot cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t prev;
    if (i == 0) begin : g_first
      assign prev = '0;
    end else begin : g_link
      assign prev = slot_q[i-1];
    end
    adq_cell #(
      .AW  (AW),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .head     (head),
      .tail_inc (tail_inc),
      .rd_pos   (rd_pos),
      .word     (cmd_ch.data_in),
      .prev     (prev),
      .slot     (slot_q[i]),
      .rd_word  (rd_word[i])
    );
  end

  // combine the gated read words
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_data = rd_data | rd_word[i];
    end
  end

  // next position, empty mark and result
  always_comb begin
    head_next   = head;
    tail_next   = tail;
    empty_next  = empty;
    data_next   = '0;
    status_next = ST_OK;
    if (is_ins) begin
      if (full) begin
        status_next = ST_OVERFLOW;
      end else if (empty) begin
        head_next  = '0;
        tail_next  = '0;
        empty_next = 1'b0;
      end else begin
        tail_next = tail_inc;
      end
    end else begin
      if (empty) begin
        data_next   = '1;
        status_next = ST_UNDERFLOW;
      end else begin
        data_next = rd_data;
        if (head == tail) begin
          head_next  = '0;
          tail_next  = '0;
          empty_next = 1'b1;
        end else if (cmd_ch.command == CMD_DEL_FRONT) begin
          head_next = head + AW'(1);
        end else begin
          tail_next = tail - AW'(1);
        end
      end
    end
  end

  // queue control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      empty <= 1'b1;
    end else if (accept) begin
      head  <= head_next;
      tail  <= tail_next;
      empty <= empty_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_data   <= data_next;
      res_status <= status_next;
    end
  end

  assign res_ch.valid    = res_valid;
  assign res_ch.data_out = res_data;
  assign res_ch.status   = res_status;

endmodule
